// ----- hdl/crdt_pkg.sv -----
// Shared types and constants for the command range dispatch table.
package crdt_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	// Operation codes
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_DISPATCH = 2'd2;

	// Outcome codes
	localparam logic [2:0] RES_ACCEPT = 3'd0;
	localparam logic [2:0] RES_REJECT = 3'd1;
	localparam logic [2:0] RES_INFO = 3'd2;
	localparam logic [2:0] RES_ROUTED = 3'd3;
	localparam logic [2:0] RES_DEFAULT = 3'd4;

	// Command space limits
	localparam logic [15:0] BASE_MAX = 16'h00FF;
	localparam logic [16:0] CODE_LIMIT = 17'h00100;

	typedef struct packed {
		logic [7:0] handle;
		logic [7:0] kind;
		logic [7:0] base;
		logic [8:0] span;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic load_fb;
		logic load_new;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HEAD,
		ST_SCAN
	} state_t;

endpackage

// ----- hdl/crdt_cell.sv -----
// One table cell: holds an entry and takes its right neighbor, the recirculated head or a new entry.
module crdt_cell (
	input  logic                clk,
	input  crdt_pkg::cell_ctrl_t ctrl,
	input  crdt_pkg::entry_t    nbr,
	input  crdt_pkg::entry_t    fb,
	input  crdt_pkg::entry_t    new_entry,
	output crdt_pkg::entry_t    entry
);
	import crdt_pkg::*;

	entry_t entry_q;

	// entry storage, no reset: only slots below the fill count are read
	always_ff @(posedge clk) begin
		if (ctrl.load_new) begin
			entry_q <= new_entry;
		end else if (ctrl.shift) begin
			entry_q <= ctrl.load_fb ? fb : nbr;
		end
	end

	assign entry = entry_q;

endmodule

// ----- hdl/command_range_dispatch_table.sv -----
// Command range dispatch table: top level with the sequencer and the ring of entry cells.
//
// Usage: items enter on the input channel (in_valid / in_stall) with op, handle, kind,
// range_base, range_span, has_handler and rx_command; results leave on the output channel
// (out_valid / out_stall), each carrying last on the final result of its item.
// The info command code is written through cfg_valid / cfg_ready / cfg_data; the user must
// write it only while idle, which the block itself does not enforce. cfg_ready is always high.
// Entries sit in a row of cells that rotates by one cell per cycle during a scan; the cell at
// the head is compared against the item at each step, so append, remove and routing pass every
// stored entry through the head before the result enters the output register. An info reply
// sends the header, then one entry per cycle while the receiver takes them. A rejected append
// caught by the input checks, or an unused op, skips the scan and is answered with a reject.
// One item is in work at a time; in_stall is high until its last result is loaded into the
// output register, which then waits for the receiver independently, and the next item can be
// accepted in the cycle after that load. When the receiver stalls, the output register holds
// its result and the rotation pauses only on an info reply. Reset clears the fill count, the
// info command (to zero) and the output valid; entry cells are not cleared.
module command_range_dispatch_table (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [7:0] handle,
	input  logic [7:0] kind,
	input  logic [15:0] range_base,
	input  logic [15:0] range_span,
	input  logic       has_handler,
	input  logic [7:0] rx_command,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] outcome,
	output logic [7:0] out_handle,
	output logic [7:0] out_kind,
	output logic [7:0] out_base,
	output logic [8:0] out_span,
	output logic [4:0] entry_total,
	output logic       last,
	// configuration channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);
	import crdt_pkg::*;

	state_t state_q, state_d;

	logic [7:0]       info_cmd_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] steps_q, steps_d;
	logic [1:0]       op_q;
	logic [7:0]       handle_q, kind_q, base_q, rx_q;
	logic [8:0]       span_q;
	logic             is_info_q, fail_q, fail_d, found_q, found_d;
	logic [7:0]       hit_q, hit_d;

	logic             in_acc, slot_free, ld_out, step_en, drop, wr_new;
	logic             out_valid_q;
	logic [2:0]       outcome_d, outcome_q;
	entry_t           res_entry_d, res_entry_q;
	logic [4:0]       total_d, total_q;
	logic             last_d, last_q;

	entry_t           cell_q [MAX_ENTRIES];
	entry_t           head, new_entry;
	cell_ctrl_t       cell_ctrl [MAX_ENTRIES];

	// input checks for append
	logic [16:0] in_end;
	logic        info_hit, pre_ok;

	assign in_end = {1'b0, range_base} + {1'b0, range_span};
	assign info_hit = ({8'd0, info_cmd_q} >= range_base) && ({9'd0, info_cmd_q} < in_end);
	assign pre_ok = (kind != 8'd0) && (range_span != 16'd0) && has_handler &&
		(range_base <= BASE_MAX) && (in_end <= CODE_LIMIT) && !info_hit &&
		(count_q < CNT_W'(MAX_ENTRIES));

	// head compares
	logic [9:0] head_end, new_end;
	logic       dup, ovl, in_range;

	assign head = cell_q[0];
	assign head_end = {2'd0, head.base} + {1'b0, head.span};
	assign new_end = {2'd0, base_q} + {1'b0, span_q};
	assign dup = (head.handle == handle_q);
	assign ovl = ({2'd0, base_q} < head_end) && ({2'd0, head.base} < new_end);
	assign in_range = (rx_q >= head.base) && ({2'd0, rx_q} < head_end);

	assign new_entry = '{handle: handle_q, kind: kind_q, base: base_q, span: span_q};

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// sequencer: next state and output load
	always_comb begin
		state_d = state_q;
		steps_d = steps_q;
		fail_d = fail_q;
		found_d = found_q;
		hit_d = hit_q;
		step_en = 1'b0;
		drop = 1'b0;
		wr_new = 1'b0;
		ld_out = 1'b0;
		outcome_d = RES_REJECT;
		res_entry_d = '0;
		total_d = 5'd0;
		last_d = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					steps_d = count_q;
					found_d = 1'b0;
					fail_d = 1'b0;
					if ((op == OP_APPEND && !pre_ok) ||
						(op != OP_APPEND && op != OP_REMOVE && op != OP_DISPATCH)) begin
						fail_d = 1'b1;
						steps_d = '0;
					end
					if (op == OP_DISPATCH && rx_command == info_cmd_q) begin
						state_d = ST_HEAD;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_HEAD: begin
				if (slot_free) begin
					ld_out = 1'b1;
					outcome_d = RES_INFO;
					total_d = 5'(count_q);
					last_d = (count_q == '0);
					state_d = (count_q == '0) ? ST_IDLE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (is_info_q) begin
					// list one entry per cycle while the output slot is free
					if (steps_q == '0) begin
						state_d = ST_IDLE;
					end else if (slot_free) begin
						step_en = 1'b1;
						ld_out = 1'b1;
						outcome_d = RES_INFO;
						res_entry_d = head;
						last_d = (steps_q == CNT_W'(1));
						steps_d = steps_q - CNT_W'(1);
						if (steps_q == CNT_W'(1)) begin
							state_d = ST_IDLE;
						end
					end
				end else if (steps_q != '0) begin
					// compare the head and rotate
					step_en = 1'b1;
					steps_d = steps_q - CNT_W'(1);
					unique case (op_q)
						OP_APPEND: begin
							fail_d = fail_q || dup || ovl;
						end
						OP_REMOVE: begin
							if (!found_q && dup) begin
								drop = 1'b1;
								found_d = 1'b1;
							end
						end
						OP_DISPATCH: begin
							if (!found_q && in_range) begin
								found_d = 1'b1;
								hit_d = head.handle;
							end
						end
						default: begin
						end
					endcase
				end else if (slot_free) begin
					// scan done: single result
					ld_out = 1'b1;
					state_d = ST_IDLE;
					priority if (fail_q) begin
						outcome_d = RES_REJECT;
					end else if (op_q == OP_APPEND) begin
						outcome_d = RES_ACCEPT;
						wr_new = 1'b1;
					end else if (op_q == OP_REMOVE) begin
						outcome_d = found_q ? RES_ACCEPT : RES_REJECT;
					end else begin
						outcome_d = found_q ? RES_ROUTED : RES_DEFAULT;
						res_entry_d.handle = found_q ? hit_q : 8'd0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign count_d = count_q + CNT_W'(wr_new) - CNT_W'(drop);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			steps_q <= '0;
			info_cmd_q <= 8'd0;
			fail_q <= 1'b0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			steps_q <= steps_d;
			fail_q <= fail_d;
			found_q <= found_d;
			if (cfg_valid && cfg_ready) begin
				info_cmd_q <= cfg_data;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		hit_q <= hit_d;
		if (in_acc) begin
			op_q <= op;
			handle_q <= handle;
			kind_q <= kind;
			base_q <= range_base[7:0];
			span_q <= range_span[8:0];
			rx_q <= rx_command;
			is_info_q <= (op == OP_DISPATCH) && (rx_command == info_cmd_q);
		end
		if (ld_out) begin
			outcome_q <= outcome_d;
			res_entry_q <= res_entry_d;
			total_q <= total_d;
			last_q <= last_d;
		end
	end

	// ring of cells
	genvar gi;
	generate
		for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
			entry_t nbr;
			if (gi == MAX_ENTRIES - 1) begin : g_end
				assign nbr = cell_q[gi];
			end else begin : g_mid
				assign nbr = cell_q[gi + 1];
			end
			assign cell_ctrl[gi] = '{
				shift: step_en,
				load_fb: !drop && (CNT_W'(gi + 1) == count_q),
				load_new: wr_new && (CNT_W'(gi) == count_q)
			};
			crdt_cell u_cell (
				.clk(clk),
				.ctrl(cell_ctrl[gi]),
				.nbr(nbr),
				.fb(head),
				.new_entry(new_entry),
				.entry(cell_q[gi])
			);
		end
	endgenerate

	assign out_valid = out_valid_q;
	assign outcome = outcome_q;
	assign out_handle = res_entry_q.handle;
	assign out_kind = res_entry_q.kind;
	assign out_base = res_entry_q.base;
	assign out_span = res_entry_q.span;
	assign entry_total = total_q;
	assign last = last_q;

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("fill count above table size");
	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_new |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("append did not grow the table");
	a_drop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		drop |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("remove did not shrink the table");
	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> steps_q <= count_q)
		else $error("scan steps exceed stored entries");
	a_no_double_drop: assert property (@(posedge clk) disable iff (!arst_n)
		drop |-> !found_q && !wr_new)
		else $error("second removal in one transaction");
`endif

endmodule
